### hw/rtl/dpt_pkg.sv
// Shared constants and types for the derivative pulse trigger.
`default_nettype none

package dpt_pkg;

	// Fixed field widths
	localparam int POS_W    = 24;
	localparam int THR_W    = 17;
	localparam int WIN_W    = 12;
	localparam int LEN_W    = 24;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	// Parameter defaults
	localparam int STEP_DEF        = 20;
	localparam int SAMPLE_BITS_DEF = 16;

	// Register reset values
	localparam logic signed [THR_W-1:0] THRESHOLD_RST = -17'sd64;
	localparam logic [WIN_W-1:0]        PRE_RST       = 12'd100;
	localparam logic [WIN_W-1:0]        POST_RST      = 12'd500;
	localparam logic [LEN_W-1:0]        RECLEN_RST    = 24'd1000000;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD = 2'd0,
		REG_PRE       = 2'd1,
		REG_POST      = 2'd2,
		REG_RECLEN    = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

### hw/rtl/derivative_pulse_trigger_unit.sv
// Derivative threshold trigger with hold-off over fixed-length sample records.
//
// Usage: samples enter on in_valid/in_stall, one beat per sample; a beat is
// taken at a clock edge with valid high and stall low. Each sample at record
// position p >= STEP is compared with the sample STEP earlier, kept in a
// STEP-entry synchronous delay memory addressed by a slot counter. When armed
// and the difference drops below threshold inside the allowed window, one
// result beat (trigger_position, window_start, slope_value) leaves on
// out_valid/out_stall. A beat passes stage 1, then the output register.
// Throughput is one sample per cycle while in_stall is low: the memory is
// read and written once per beat and the armed/hold-off state updates in a
// single stage. When the receiver stalls, the result waits in the output
// register; samples that produce no result keep flowing, and in_stall rises
// only when a second result is ready behind the waiting one. Reset clears
// position, armed state, hold-off mark and the registers to their defaults;
// the delay memory is not cleared, since an entry is only read after it was
// written in the same record. The user must write configuration on
// cfg_we/cfg_index/cfg_data only while the block is idle; it is not enforced.
`default_nettype none

module derivative_pulse_trigger_unit #(
	parameter int STEP        = dpt_pkg::STEP_DEF,
	parameter int SAMPLE_BITS = dpt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration
	input  wire logic                               cfg_we,
	input  wire logic [dpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [dpt_pkg::CFG_W-1:0]          cfg_data,
	// sample input
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]      sample,
	// trigger output
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [dpt_pkg::POS_W-1:0]               trigger_position,
	output logic [dpt_pkg::POS_W-1:0]               window_start,
	output logic signed [dpt_pkg::THR_W-1:0]        slope_value
);
	import dpt_pkg::*;

	localparam int SLOT_W = (STEP > 1) ? $clog2(STEP) : 1;
	localparam int DW     = SAMPLE_BITS + 1;
	localparam int CW     = (DW > THR_W) ? DW : THR_W;

	// Configuration registers
	logic signed [THR_W-1:0] thr_q;
	logic [WIN_W-1:0]        pre_q;
	logic [WIN_W-1:0]        post_q;
	logic [LEN_W-1:0]        reclen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THRESHOLD_RST;
			pre_q    <= PRE_RST;
			post_q   <= POST_RST;
			reclen_q <= RECLEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD: thr_q    <= $signed(cfg_data[THR_W-1:0]);
				REG_PRE:       pre_q    <= cfg_data[WIN_W-1:0];
				REG_POST:      post_q   <= cfg_data[WIN_W-1:0];
				REG_RECLEN:    reclen_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// Handshake and stage-1 flow
	logic accept;
	logic s1_valid_q;
	logic fire;
	logic s1_block;
	logic s1_go;
	logic out_valid_q;

	assign s1_block = fire && out_valid_q && out_stall;
	assign s1_go    = s1_valid_q && !s1_block;
	assign in_stall = s1_block;
	assign accept   = in_valid && !in_stall;

	// Stage 0: record position and delay slot
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_q;
	logic [POS_W-1:0]  idx0;
	logic              has_ref0;
	logic              past_pre0;
	logic              fits0;
	logic              rec_end0;

	assign has_ref0  = pos_q >= POS_W'(STEP);
	assign idx0      = pos_q - POS_W'(STEP);
	assign past_pre0 = idx0 > POS_W'(pre_q);
	assign fits0     = ({1'b0, pos_q} + (POS_W+1)'(post_q)) < {1'b0, reclen_q};
	assign rec_end0  = ({1'b0, pos_q} + (POS_W+1)'(1)) >= {1'b0, reclen_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (rec_end0) begin
				pos_q  <= '0;
				slot_q <= '0;
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				slot_q <= (slot_q == SLOT_W'(STEP - 1)) ? '0 : slot_q + SLOT_W'(1);
			end
		end
	end

	// Delay memory: read-first, one read and one write per beat
	logic signed [SAMPLE_BITS-1:0] dly_mem [STEP];
	logic signed [SAMPLE_BITS-1:0] old_s1;
	logic signed [SAMPLE_BITS-1:0] x_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1         <= dly_mem[slot_q];
			dly_mem[slot_q] <= sample;
			x_s1           <= sample;
		end
	end

	// Stage-1 payload
	logic [POS_W-1:0] idx_s1;
	logic             has_ref_s1;
	logic             past_pre_s1;
	logic             fits_s1;
	logic             rec_end_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1      <= idx0;
			has_ref_s1  <= has_ref0;
			past_pre_s1 <= past_pre0;
			fits_s1     <= fits0;
			rec_end_s1  <= rec_end0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept || s1_block;
		end
	end

	// Stage 1: difference, fire and re-arm tests
	logic signed [DW-1:0]    diff;
	logic signed [CW-1:0]    diff_c;
	logic signed [CW-1:0]    thr_c;
	logic [POS_W:0]          since_trig;
	logic                    armed_q;
	logic [POS_W-1:0]        last_trig_q;
	logic                    rearm;

	assign diff       = $signed({x_s1[SAMPLE_BITS-1], x_s1})
	                    - $signed({old_s1[SAMPLE_BITS-1], old_s1});
	assign diff_c     = CW'(diff);
	assign thr_c      = CW'(thr_q);
	assign since_trig = {1'b0, idx_s1} - {1'b0, last_trig_q};

	assign fire  = s1_valid_q && has_ref_s1 && armed_q && (diff_c < thr_c)
	               && past_pre_s1 && fits_s1;
	assign rearm = s1_valid_q && has_ref_s1 && !armed_q && (diff_c > thr_c)
	               && ($signed(since_trig) > $signed((POS_W+1)'(post_q)));

	// Armed state and hold-off mark; record end restores both
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b1;
			last_trig_q <= '0;
		end else if (s1_go) begin
			priority if (rec_end_s1) begin
				armed_q     <= 1'b1;
				last_trig_q <= '0;
			end else if (fire) begin
				armed_q     <= 1'b0;
				last_trig_q <= idx_s1;
			end else if (rearm) begin
				armed_q     <= 1'b1;
			end
		end
	end

	// Output register
	logic [POS_W-1:0]        trig_pos_q;
	logic [POS_W-1:0]        win_start_q;
	logic signed [THR_W-1:0] slope_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && fire) begin
			trig_pos_q  <= idx_s1;
			win_start_q <= idx_s1 - POS_W'(pre_q);
			slope_q     <= diff_c[THR_W-1:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign trigger_position = trig_pos_q;
	assign window_start     = win_start_q;
	assign slope_value      = slope_q;

	// Checks
	a_fire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && fire && !rec_end_s1 |=> !armed_q)
		else $error("trigger fired without disarming");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q && out_valid_q)
		else $error("input stalled with no result waiting");

	a_rec_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rec_end0 |=> pos_q == '0 && slot_q == '0)
		else $error("record end did not restart position");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(STEP - 1))
		else $error("delay slot out of range");

	a_fire_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && fire |-> idx_s1 > POS_W'(pre_q))
		else $error("trigger before pre-window");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking bench for the derivative pulse trigger: directed table, then random records.

module testbench;
	import dpt_pkg::*;

	localparam int HIST_DEPTH   = STEP_DEF;
	localparam int SW           = SAMPLE_BITS_DEF;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_LIMIT = 4000;

	// One trigger beat as it leaves the block
	typedef struct packed {
		logic [POS_W-1:0]        pos;
		logic [POS_W-1:0]        win;
		logic signed [THR_W-1:0] slope;
	} trigger_rec_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_FIRES} row_check_t;
	typedef enum logic {STIM_PULSES, STIM_NOISE} stim_mode_t;

	// Directed row: one sample value repeated, with the typed trigger for ROW_FIRES
	typedef struct packed {
		logic signed [SW-1:0]    value;
		logic [7:0]              reps;
		row_check_t              check;
		logic [POS_W-1:0]        pos;
		logic [POS_W-1:0]        win;
		logic signed [THR_W-1:0] slope;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_reg_t cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic signed [SW-1:0] sample;
	logic out_valid;
	logic out_stall;
	logic [POS_W-1:0] trigger_position;
	logic [POS_W-1:0] window_start;
	logic signed [THR_W-1:0] slope_value;

	derivative_pulse_trigger_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trigger_position(trigger_position),
		.window_start(window_start),
		.slope_value(slope_value)
	);

	always #6 clk = ~clk;

	// Trigger model state and register copies
	logic signed [SW-1:0] sample_hist [HIST_DEPTH];
	int unsigned rec_pos;
	bit is_armed;
	longint last_fire;
	longint cur_thr, cur_pre, cur_post, cur_len;

	trigger_rec_t pending_triggers [$];
	dir_row_t directed_rows [$];

	int errors = 0;
	int samples_sent = 0;
	int triggers_seen = 0;
	int phases_run = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	// Pulse shape generator state
	int gen_base = 0;
	int gen_amp = 0;
	int gen_left = 0;

	// Append one expected trigger at the tail of the scoreboard
	function automatic void expect_trigger(input trigger_rec_t rec);
		pending_triggers.insert(pending_triggers.size(), rec);
	endfunction

	// Append one row at the end of the directed table
	function automatic void add_row(input dir_row_t row);
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// Work out the trigger, if any, caused by one accepted sample
	function automatic void predict_trigger(input logic signed [SW-1:0] x,
			output bit fired, output trigger_rec_t rec);
		longint d, i;
		int unsigned p, slot;
		bit fits;
		p = rec_pos;
		slot = p % HIST_DEPTH;
		fired = 1'b0;
		rec = '0;
		if (p >= HIST_DEPTH) begin
			d = longint'(x) - longint'(sample_hist[slot]);
			i = longint'(p) - HIST_DEPTH;
			fits = (i + cur_post) < (cur_len - HIST_DEPTH);
			if (is_armed && d < cur_thr && i > cur_pre && fits) begin
				fired = 1'b1;
				rec.pos = POS_W'(i);
				rec.win = POS_W'(i - cur_pre);
				rec.slope = THR_W'(d);
				last_fire = i;
				is_armed = 1'b0;
			end
			// re-arm only once the slope recovered and the hold-off ran out
			if (!is_armed && d > cur_thr && (i - last_fire) > cur_post)
				is_armed = 1'b1;
		end
		sample_hist[slot] = x;
		if (longint'(p) + 1 >= cur_len) begin
			rec_pos = 0;
			is_armed = 1'b1;
			last_fire = 0;
		end else begin
			rec_pos = (p + 1) & 32'hFF_FFFF;
		end
	endfunction

	// Window start equals position here: the directed table runs with pre at zero
	function automatic dir_row_t mk_row(input int value, input int reps, input row_check_t chk,
			input int pos = 0, input int slope = 0);
		dir_row_t r;
		r.value = SW'(value);
		r.reps = 8'(reps);
		r.check = chk;
		r.pos = POS_W'(pos);
		r.win = POS_W'(pos);
		r.slope = THR_W'(slope);
		return r;
	endfunction

	// Flat baseline with noise, sharp negative pulses, and some full-range junk; STIM_NOISE gives only junk
	function automatic logic signed [SW-1:0] next_sample(input stim_mode_t mode);
		int v;
		if (mode == STIM_NOISE || $urandom_range(99) < 8)
			return SW'($urandom());
		if (gen_left == 0 && $urandom_range(99) < 5) begin
			gen_base = int'($urandom_range(20000)) - 10000;
			gen_amp = $urandom_range(30, 22000);
			gen_left = $urandom_range(2, 40);
		end
		v = gen_base + int'($urandom_range(16)) - 8;
		if (gen_left > 0) begin
			v -= gen_amp;
			gen_left--;
		end
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return SW'(v);
	endfunction

	// Write all four registers, one per clock, and mirror them
	task automatic apply_config(input int thr, input int pre, input int post, input int len);
		logic signed [THR_W-1:0] t17;
		cfg_we <= 1'b1;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= CFG_W'(thr);
		@(posedge clk);
		cfg_index <= REG_PRE;
		cfg_data <= CFG_W'(pre);
		@(posedge clk);
		cfg_index <= REG_POST;
		cfg_data <= CFG_W'(post);
		@(posedge clk);
		cfg_index <= REG_RECLEN;
		cfg_data <= CFG_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		t17 = THR_W'(thr);
		cur_thr = t17;
		cur_pre = pre & 12'hFFF;
		cur_post = post & 12'hFFF;
		cur_len = len & 24'hFF_FFFF;
	endtask

	// Offer one sample beat with random gaps; predict once it is taken
	task automatic drive_sample(input logic signed [SW-1:0] x, output bit fired,
			output trigger_rec_t rec);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= x;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		samples_sent++;
		predict_trigger(x, fired, rec);
	endtask

	// Wait for outstanding triggers, then for anything still in flight; report any that never arrived
	task automatic settle_results();
		int waited;
		waited = 0;
		while (pending_triggers.size() != 0 && waited < SETTLE_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (pending_triggers.size() != 0) begin
			$display("%0t: %0d expected triggers never arrived, first pos %0d",
				$time, pending_triggers.size(), pending_triggers[0].pos);
			errors += pending_triggers.size();
			pending_triggers.delete();
		end
	endtask

	// One register setting and a stream of samples
	task automatic run_phase(input int thr, input int pre, input int post, input int len,
			input int count, input stim_mode_t mode, input bit pause_mid, input bit hold_mid);
		bit fired;
		trigger_rec_t rec;
		int k;
		logic signed [SW-1:0] x;
		apply_config(thr, pre, post, len);
		for (k = 0; k < count; k++) begin
			if (hold_mid && k == 20)
				hold_req = 1'b1;
			// sender goes quiet until every trigger so far is out
			if (pause_mid && k == count / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending_triggers.size() != 0)
					@(posedge clk);
			end
			x = next_sample(mode);
			drive_sample(x, fired, rec);
			if (fired)
				expect_trigger(rec);
		end
		in_valid <= 1'b0;
		settle_results();
		phases_run++;
	endtask

	// Receiver: check each trigger beat, then pick the next stall
	always @(posedge clk) begin
		trigger_rec_t exp_rec;
		if (arst_n && out_valid && !out_stall) begin
			triggers_seen++;
			if (pending_triggers.size() == 0) begin
				$display("%0t: unexpected trigger: got pos %0d win %0d slope %0d",
					$time, trigger_position, window_start, slope_value);
				errors++;
			end else begin
				exp_rec = pending_triggers.pop_front();
				if (trigger_position !== exp_rec.pos || window_start !== exp_rec.win ||
						slope_value !== exp_rec.slope) begin
					$display("%0t: trigger mismatch: expected pos %0d win %0d slope %0d,",
						$time, exp_rec.pos, exp_rec.win, exp_rec.slope);
					$display("    got pos %0d win %0d slope %0d",
						trigger_position, window_start, slope_value);
					errors++;
				end
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	// Stimulus
	initial begin
		bit fired;
		trigger_rec_t rec;
		int k;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = '0;
		out_stall = 1'b0;
		foreach (sample_hist[j])
			sample_hist[j] = '0;
		rec_pos = 0;
		is_armed = 1'b1;
		last_fire = 0;
		cur_thr = THRESHOLD_RST;
		cur_pre = PRE_RST;
		cur_post = POST_RST;
		cur_len = RECLEN_RST;

		// Record of 30: fires at the most negative slope, on the threshold edge,
		// after re-arm, at the last fitting index; then a second record
		add_row(mk_row(0, 1, ROW_QUIET));
		add_row(mk_row(32767, 1, ROW_QUIET));
		add_row(mk_row(0, 19, ROW_QUIET));
		add_row(mk_row(-32768, 1, ROW_FIRES, 1, -65535));
		add_row(mk_row(32767, 1, ROW_QUIET));
		add_row(mk_row(-100, 1, ROW_FIRES, 3, -100));
		add_row(mk_row(-100, 1, ROW_QUIET));
		add_row(mk_row(0, 1, ROW_QUIET));
		add_row(mk_row(-64, 1, ROW_QUIET));
		add_row(mk_row(-65, 1, ROW_FIRES, 7, -65));
		add_row(mk_row(0, 1, ROW_QUIET));
		add_row(mk_row(-200, 1, ROW_FIRES, 9, -200));
		add_row(mk_row(0, 1, ROW_QUIET));
		add_row(mk_row(-32768, 1, ROW_QUIET));
		add_row(mk_row(0, 18, ROW_QUIET));
		add_row(mk_row(-32768, 1, ROW_QUIET));
		add_row(mk_row(32767, 1, ROW_QUIET));
		add_row(mk_row(-32768, 1, ROW_FIRES, 2, -32768));
		add_row(mk_row(-5000, 7, ROW_PREDICT));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		src_idle_pct = 26;
		sink_idle_pct = 56;
		apply_config(-64, 0, 0, 30);
		foreach (directed_rows[r]) begin
			for (k = 0; k < directed_rows[r].reps; k++) begin
				drive_sample(directed_rows[r].value, fired, rec);
				case (directed_rows[r].check)
					ROW_PREDICT: begin
						if (fired)
							expect_trigger(rec);
					end
					ROW_FIRES: begin
						expect_trigger({directed_rows[r].pos,
							directed_rows[r].win, directed_rows[r].slope});
					end
					default: begin
					end
				endcase
			end
		end
		in_valid <= 1'b0;
		settle_results();

		// Random records: thr, pre, post, length, beats, shape, pause, hold-off
		run_phase(-64, 10, 20, 200, 300, STIM_PULSES, 1'b0, 1'b0);
		run_phase(-1000, 50, 100, 400, 350, STIM_PULSES, 1'b1, 1'b0);
		run_phase(0, 0, 0, 16777215, 300, STIM_NOISE, 1'b0, 1'b1);
		src_idle_pct = 56;
		sink_idle_pct = 26;
		run_phase(65535, 5, 3, 120, 200, STIM_PULSES, 1'b0, 1'b0);
		run_phase(-65535, 4095, 0, 300, 100, STIM_NOISE, 1'b0, 1'b0);
		run_phase(-500, 0, 0, 1, 40, STIM_PULSES, 1'b0, 1'b0);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_phase(-200, 0, 4095, 4200, 200, STIM_PULSES, 1'b0, 1'b0);
		run_phase(0, 0, 0, 0, 30, STIM_NOISE, 1'b0, 1'b0);
		run_phase(-64, 100, 500, 1000000, 330, STIM_PULSES, 1'b0, 1'b0);

		$display("Run covered %0d samples over %0d register settings plus the directed table,",
			samples_sent, phases_run);
		$display("record ends, zero and unit lengths, a %0d-cycle receiver hold-off; %0d triggers",
			HOLD_CYCLES, triggers_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#8000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
